// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CKP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CKP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ckp_pkg.sv =====
// ============================================================================
// ckp_pkg
// types, constants and helpers for the hsv chroma key pixel pipeline
// ============================================================================
package ckp_pkg;

    localparam int COMP_W   = 8;
    localparam int CMAX     = (1 << COMP_W) - 1;
    localparam int CENTER_W = 9;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;
    localparam int DVD_W    = 20;   // divider dividend and remainder
    localparam int QUO_W    = 12;   // divider quotient bits, one per step
    localparam int HQ_W     = 15;   // hue in degrees times 64
    localparam int WIN_W    = 26;   // signed window bounds
    localparam int NUM_STG  = QUO_W + 3;

    localparam logic [HQ_W-1:0] HUE_GREEN = HQ_W'(7680);
    localparam logic [HQ_W-1:0] HUE_BLUE  = HQ_W'(15360);
    localparam logic [HQ_W-1:0] HUE_FULL  = HQ_W'(23040);

    localparam logic [IDX_W-1:0] REG_HUE_CENTER = 3'd0;
    localparam logic [IDX_W-1:0] REG_HUE_WIDTH  = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_SAT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SMOOTHING  = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_VALUE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_VALUE  = 3'd5;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE,
        SECT_GRAY
    } t_sect;

    typedef struct packed {
        logic [COMP_W-1:0] b;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] a;
        logic              last;
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] dif;
        t_sect             sect;
        logic              neg;
        logic [COMP_W-1:0] num;
        logic              sat_ok;
        logic [DVD_W-1:0]  rem1;
        logic [DVD_W-1:0]  rem2;
        logic [DVD_W-1:0]  rem3;
        logic [QUO_W-1:0]  quo1;
        logic [QUO_W-1:0]  quo2;
        logic [QUO_W-1:0]  quo3;
        logic [HQ_W-1:0]   hq;
        logic [COMP_W-1:0] alpha_lo;
        logic [COMP_W-1:0] alpha_hi;
    } t_stage;

    typedef struct packed {
        logic [COMP_W-1:0] b;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] a;
        logic              keyed;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [DVD_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_dstep;

    // one restoring division step producing quotient bit sh
    function automatic t_dstep div_step(input logic [DVD_W-1:0] rem,
                                        input logic [QUO_W-1:0] quo,
                                        input logic [COMP_W-1:0] dvs,
                                        input int unsigned sh);
        logic [DVD_W-1:0] sd;
        t_dstep           res;
        sd      = DVD_W'(dvs) << sh;
        res.rem = rem;
        res.quo = quo;
        if (rem >= sd) begin
            res.rem = rem - sd;
            res.quo = quo | (QUO_W'(1) << sh);
        end
        return res;
    endfunction

    // x * 255
    function automatic logic [DVD_W-1:0] mul255(input logic [COMP_W-1:0] x);
        return (DVD_W'(x) << 8) - DVD_W'(x);
    endfunction

endpackage

// ===== rtl/core/ckp_pix_if.sv =====
// ============================================================================
// ckp_pix_if
// input pixel channel: valid/ready with one bgra pixel and frame end flag
// ============================================================================
interface ckp_pix_if;
    import ckp_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] blue_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] alpha_in;
    logic              last_pixel;

    modport source (
        output valid, blue_in, green_in, red_in, alpha_in, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, blue_in, green_in, red_in, alpha_in, last_pixel,
        output ready
    );
endinterface

// ===== rtl/core/ckp_res_if.sv =====
// ============================================================================
// ckp_res_if
// result pixel channel: valid/ready with keyed bgra pixel and flags
// ============================================================================
interface ckp_res_if;
    import ckp_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] blue_out;
    logic [COMP_W-1:0] green_out;
    logic [COMP_W-1:0] red_out;
    logic [COMP_W-1:0] alpha_out;
    logic              keyed;
    logic              last_out;

    modport source (
        output valid, blue_out, green_out, red_out, alpha_out, keyed, last_out,
        input  ready
    );

    modport sink (
        input  valid, blue_out, green_out, red_out, alpha_out, keyed, last_out,
        output ready
    );
endinterface

// ===== rtl/core/chroma_key_pixel_unit.sv =====
// ============================================================================
// chroma_key_pixel_unit
// hsv chroma keyer: one bgra pixel per clock unless stalled, keyed pixels go gray with alpha
// ============================================================================
// Takes one pixel per clock while the output is not stalled and returns one
// result per pixel, in order. A pixel passes 16 register stages in the block,
// the pipeline stages and then the output register. This depth is set by the
// 12-step restoring divider that forms the hue, with the band alpha quotients
// riding in the same stages. Every stage holds its item on its own valid bit
// and a bubble is filled while the output waits. Registers must be written over
// the apb port only while no pixel is in flight; the block does not enforce this.
`include "assert_macros.svh"

module chroma_key_pixel_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ckp_pkg::ADDR_W-1:0] paddr,
    input  logic [ckp_pkg::DATA_W-1:0] pwdata,
    output logic [ckp_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    ckp_pix_if.sink                   i_pix,
    ckp_res_if.source                 o_res
);
    import ckp_pkg::*;

    // configuration
    logic [CENTER_W-1:0] r_hue_center;
    logic [CENTER_W-1:0] r_hue_width;
    logic [COMP_W-1:0]   r_min_sat;
    logic [COMP_W-1:0]   r_smoothing;
    logic [COMP_W-1:0]   r_min_value;
    logic [COMP_W-1:0]   r_max_value;
    logic [IDX_W-1:0]    reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_center <= CENTER_W'(120);
            r_hue_width  <= CENTER_W'(30);
            r_min_sat    <= COMP_W'(51);
            r_smoothing  <= '0;
            r_min_value  <= COMP_W'(89);
            r_max_value  <= COMP_W'(242);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_HUE_CENTER: r_hue_center <= pwdata[CENTER_W-1:0];
                REG_HUE_WIDTH:  r_hue_width  <= pwdata[CENTER_W-1:0];
                REG_MIN_SAT:    r_min_sat    <= pwdata[COMP_W-1:0];
                REG_SMOOTHING:  r_smoothing  <= pwdata[COMP_W-1:0];
                REG_MIN_VALUE:  r_min_value  <= pwdata[COMP_W-1:0];
                REG_MAX_VALUE:  r_max_value  <= pwdata[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HUE_CENTER: prdata = DATA_W'(r_hue_center);
            REG_HUE_WIDTH:  prdata = DATA_W'(r_hue_width);
            REG_MIN_SAT:    prdata = DATA_W'(r_min_sat);
            REG_SMOOTHING:  prdata = DATA_W'(r_smoothing);
            REG_MIN_VALUE:  prdata = DATA_W'(r_min_value);
            REG_MAX_VALUE:  prdata = DATA_W'(r_max_value);
            default:        prdata = '0;
        endcase
    end

    // window bounds, hue times 64 times 255, refreshed every cycle
    logic [WIN_W-1:0]  r_win_lo;
    logic [WIN_W-1:0]  r_win_hi;
    logic [WIN_W-1:0]  n_win_lo;
    logic [WIN_W-1:0]  n_win_hi;
    logic [WIN_W-1:0]  base_lo;
    logic [WIN_W-1:0]  base_hi;
    logic [WIN_W-1:0]  margin;
    logic [WIN_W-1:0]  smooth_inv;
    logic [COMP_W-1:0] den_hi;

    always_comb begin
        base_lo    = (WIN_W'(r_hue_center) << 6) - (WIN_W'(r_hue_width) << 5);
        base_hi    = (WIN_W'(r_hue_center) << 6) + (WIN_W'(r_hue_width) << 5);
        smooth_inv = WIN_W'(CMAX) - WIN_W'(r_smoothing);
        margin     = (smooth_inv << 11) + (smooth_inv << 8);
        n_win_lo   = (base_lo << 8) - base_lo - margin;
        n_win_hi   = (base_hi << 8) - base_hi + margin;
    end

    always_ff @(posedge i_clk) begin
        r_win_lo <= n_win_lo;
        r_win_hi <= n_win_hi;
    end

    assign den_hi = COMP_W'(CMAX) - r_max_value;

    // pipeline
    t_stage             r_stg [NUM_STG];
    t_stage             n_stg [NUM_STG];
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] en;
    t_res               r_res;
    t_res               n_res;
    logic               r_res_vld;
    logic               en_out;

    always_comb begin
        en_out          = !r_res_vld || o_res.ready;
        en[NUM_STG-1]   = !r_vld[NUM_STG-1] || en_out;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[0];

    // stage 0: max, min, chroma and hue sector
    logic [COMP_W-1:0] s0_mn;
    logic [COMP_W-1:0] s0_p;
    logic [COMP_W-1:0] s0_q;
    always_comb begin
        n_stg[0]      = '0;
        n_stg[0].b    = i_pix.blue_in;
        n_stg[0].g    = i_pix.green_in;
        n_stg[0].r    = i_pix.red_in;
        n_stg[0].a    = i_pix.alpha_in;
        n_stg[0].last = i_pix.last_pixel;
        n_stg[0].mx   = (i_pix.red_in > i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in > n_stg[0].mx) begin
            n_stg[0].mx = i_pix.blue_in;
        end
        s0_mn = (i_pix.red_in < i_pix.green_in) ? i_pix.red_in : i_pix.green_in;
        if (i_pix.blue_in < s0_mn) begin
            s0_mn = i_pix.blue_in;
        end
        n_stg[0].dif = n_stg[0].mx - s0_mn;
        priority if (n_stg[0].dif == '0) begin
            n_stg[0].sect = SECT_GRAY;
            s0_p          = '0;
            s0_q          = '0;
        end else if (i_pix.red_in == n_stg[0].mx) begin
            n_stg[0].sect = SECT_RED;
            s0_p          = i_pix.green_in;
            s0_q          = i_pix.blue_in;
        end else if (i_pix.green_in == n_stg[0].mx) begin
            n_stg[0].sect = SECT_GREEN;
            s0_p          = i_pix.blue_in;
            s0_q          = i_pix.red_in;
        end else begin
            n_stg[0].sect = SECT_BLUE;
            s0_p          = i_pix.red_in;
            s0_q          = i_pix.green_in;
        end
        n_stg[0].neg = s0_q > s0_p;
        n_stg[0].num = n_stg[0].neg ? (s0_q - s0_p) : (s0_p - s0_q);
    end

    // stage 1: dividends and saturation test
    logic [2*COMP_W-1:0] s1_sat_lhs;
    logic [2*COMP_W-1:0] s1_sat_rhs;
    always_comb begin
        n_stg[1]      = r_stg[0];
        n_stg[1].rem1 = (DVD_W'(r_stg[0].num) << 12) - (DVD_W'(r_stg[0].num) << 8);
        n_stg[1].rem2 = mul255(r_stg[0].mx);
        n_stg[1].rem3 = (r_stg[0].mx > r_max_value) ? mul255(r_stg[0].mx - r_max_value)
                                                     : '0;
        n_stg[1].quo1 = '0;
        n_stg[1].quo2 = '0;
        n_stg[1].quo3 = '0;
        s1_sat_lhs    = (2*COMP_W)'(mul255(r_stg[0].dif));
        s1_sat_rhs    = (2*COMP_W)'(r_min_sat) * (2*COMP_W)'(r_stg[0].mx);
        n_stg[1].sat_ok = (r_stg[0].mx == '0) ? (r_min_sat == '0)
                                               : (s1_sat_lhs >= s1_sat_rhs);
    end

    // stages 2 to 13: one quotient bit per stage for all three divisions
    t_dstep d1 [NUM_STG];
    t_dstep d2 [NUM_STG];
    t_dstep d3 [NUM_STG];
    always_comb begin
        for (int k = 2; k < QUO_W + 2; k++) begin
            d1[k]         = div_step(r_stg[k-1].rem1, r_stg[k-1].quo1, r_stg[k-1].dif,
                                     (QUO_W + 1 - k));
            d2[k]         = div_step(r_stg[k-1].rem2, r_stg[k-1].quo2, r_min_value,
                                     (QUO_W + 1 - k));
            d3[k]         = div_step(r_stg[k-1].rem3, r_stg[k-1].quo3, den_hi,
                                     (QUO_W + 1 - k));
            n_stg[k]      = r_stg[k-1];
            n_stg[k].rem1 = d1[k].rem;
            n_stg[k].quo1 = d1[k].quo;
            n_stg[k].rem2 = d2[k].rem;
            n_stg[k].quo2 = d2[k].quo;
            n_stg[k].rem3 = d3[k].rem;
            n_stg[k].quo3 = d3[k].quo;
        end
        for (int k = 0; k < 2; k++) begin
            d1[k] = '0;
            d2[k] = '0;
            d3[k] = '0;
        end
        d1[NUM_STG-1] = '0;
        d2[NUM_STG-1] = '0;
        d3[NUM_STG-1] = '0;
    end

    // last pipeline stage: hue and the two band alphas
    logic [HQ_W-1:0]   s_ceil1;
    logic [QUO_W:0]    s_ceil2;
    logic [QUO_W+1:0]  s_alpha_lo;
    t_stage            s_in;
    always_comb begin
        s_in    = r_stg[NUM_STG-2];
        n_stg[NUM_STG-1] = s_in;
        s_ceil1 = HQ_W'(s_in.quo1) + HQ_W'(s_in.rem1 != '0);
        unique case (s_in.sect)
            SECT_RED:   n_stg[NUM_STG-1].hq = s_in.neg ? (HUE_FULL - s_ceil1)
                                                       : HQ_W'(s_in.quo1);
            SECT_GREEN: n_stg[NUM_STG-1].hq = s_in.neg ? (HUE_GREEN - s_ceil1)
                                                       : (HUE_GREEN + HQ_W'(s_in.quo1));
            SECT_BLUE:  n_stg[NUM_STG-1].hq = s_in.neg ? (HUE_BLUE - s_ceil1)
                                                       : (HUE_BLUE + HQ_W'(s_in.quo1));
            default:    n_stg[NUM_STG-1].hq = '0;
        endcase
        // ceil of 255*v/minv, then minv + 255 - that, clamped
        s_ceil2    = (QUO_W+1)'(s_in.quo2) + (QUO_W+1)'(s_in.rem2 != '0);
        s_alpha_lo = (QUO_W+2)'(r_min_value) + (QUO_W+2)'(CMAX) - (QUO_W+2)'(s_ceil2);
        n_stg[NUM_STG-1].alpha_lo = (s_alpha_lo > (QUO_W+2)'(CMAX)) ? COMP_W'(CMAX)
                                                                    : s_alpha_lo[COMP_W-1:0];
        if (den_hi == '0 || s_in.quo3 > QUO_W'(CMAX)) begin
            n_stg[NUM_STG-1].alpha_hi = COMP_W'(CMAX);
        end else begin
            n_stg[NUM_STG-1].alpha_hi = s_in.quo3[COMP_W-1:0];
        end
    end

    // output register: window test and pixel rewrite
    logic [WIN_W-1:0] o_hue_sc;
    t_stage           o_in;
    always_comb begin
        o_in        = r_stg[NUM_STG-1];
        o_hue_sc    = (WIN_W'(o_in.hq) << 8) - WIN_W'(o_in.hq);
        n_res.b     = o_in.b;
        n_res.g     = o_in.g;
        n_res.r     = o_in.r;
        n_res.a     = o_in.a;
        n_res.last  = o_in.last;
        n_res.keyed = ($signed(o_hue_sc) >= $signed(r_win_lo))
                   && ($signed(o_hue_sc) <= $signed(r_win_hi));
        if (n_res.keyed) begin
            priority if (!o_in.sat_ok) begin
                n_res.b = o_in.mx;
                n_res.a = COMP_W'(CMAX);
            end else if (o_in.mx >= r_min_value && o_in.mx <= r_max_value) begin
                n_res.b = o_in.mx;
                n_res.a = '0;
            end else if (o_in.mx < r_min_value) begin
                n_res.b = '0;
                n_res.a = o_in.alpha_lo;
            end else begin
                n_res.b = COMP_W'(CMAX);
                n_res.a = o_in.alpha_hi;
            end
            n_res.g = n_res.b;
            n_res.r = n_res.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en_out) begin
                r_res_vld <= r_vld[NUM_STG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STG; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
        if (en_out) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid     = r_res_vld;
    assign o_res.blue_out  = r_res.b;
    assign o_res.green_out = r_res.g;
    assign o_res.red_out   = r_res.r;
    assign o_res.alpha_out = r_res.a;
    assign o_res.keyed     = r_res.keyed;
    assign o_res.last_out  = r_res.last;

    // assertion terms
    logic res_keyed;
    logic res_gray;
    logic res_alpha_part;
    logic res_rail;
    assign res_keyed      = r_res_vld && r_res.keyed;
    assign res_gray       = (r_res.b == r_res.g) && (r_res.g == r_res.r);
    assign res_alpha_part = (r_res.a != '0) && (r_res.a != COMP_W'(CMAX));
    assign res_rail       = (r_res.b == '0) || (r_res.b == COMP_W'(CMAX));

    // keyed pixels are always a single gray level
    `CKP_ASSERT_IMP(a_keyed_gray, res_keyed, res_gray)
    // partial alpha only comes from the black or white rules
    `CKP_ASSERT_IMP(a_partial_alpha, res_keyed && res_alpha_part, res_rail)
    // a waiting result is never dropped by the pipeline
    `CKP_ASSERT_NXT(a_hold_result, r_res_vld && !o_res.ready, r_res_vld && $stable(r_res))

endmodule
